// ===== rtl/mpstlb_pkg.sv =====
// ============================================================================
// mpstlb_pkg
// Shared types, widths and constants of the mixed page size TLB.
// ============================================================================
`default_nettype none

package mpstlb_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam int VA_W    = 64;
    localparam int PA_W    = 52;
    localparam int SZ_W    = 2;
    localparam int LEN_W   = 13;
    localparam int OFF_W   = 30;   // largest page is 1 GiB
    localparam int PAGE_W  = 31;   // holds page size and offset plus length
    localparam int ST_W    = 3;
    localparam int IN_W    = 136;  // 131 payload bits, padded to bytes
    localparam int OUT_W   = 64;   // 57 payload bits, padded to bytes

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_XLATE  = 1'b1;

    localparam logic [SZ_W-1:0] SZ_4K = 2'd0;
    localparam logic [SZ_W-1:0] SZ_2M = 2'd1;
    localparam logic [SZ_W-1:0] SZ_1G = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_MISS    = 3'd1,
        ST_CROSS   = 3'd2,
        ST_COVERED = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        logic [VA_W-1:0] virt;
        logic [PA_W-1:0] phys;
        logic [SZ_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic             covered;
        logic [OFF_W-1:0] off;
    } cover_t;

    // page bytes for a stored size code; code three reads as 1 GiB
    function automatic logic [PAGE_W-1:0] page_bytes(input logic [SZ_W-1:0] code);
        logic [PAGE_W-1:0] bytes;
        unique case (code)
            SZ_4K:   bytes = PAGE_W'(4096);
            SZ_2M:   bytes = PAGE_W'(2097152);
            default: bytes = PAGE_W'(1073741824);
        endcase
        return bytes;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mixed_page_size_tlb.sv =====
// ============================================================================
// mixed_page_size_tlb
// Fully associative TLB of 4 KiB / 2 MiB / 1 GiB mappings, scanned newest
// first out of a single entry memory.
// ============================================================================
//
// channel  dir  fields
// -------  ---  ---------------------------------------------------------
// s_*      in   tuser: mode; tdata: virt_addr, map_phys_addr,
//               page_size_code, access_len
// m_*      out  tdata: status, phys_out, hit_size_code
//
// Steps: an accept step that issues the read of the newest entry (or goes
// to finish on an empty store), then one memory read per stored entry from
// the newest down until a cover is found or the oldest is checked, then a
// finish step. The single-read-port entry memory checks one entry at a time.
// Reset: fill count cleared; the entry memory is not cleared, since only
// entries below the fill count are ever read.
// Stalls: the result waits in the output register; the next word is taken
// meanwhile and holds in the finish cycle until the output register frees.
// Insert writes land in the finish cycle, before any later read is issued,
// so reads and writes of one entry never overlap.
// ============================================================================
`default_nettype none

module mixed_page_size_tlb
    import mpstlb_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // [63:0] virt_addr, [115:64] map_phys_addr, [117:116] page_size_code,
    // [130:118] access_len, [135:131] zero
    input  wire logic [IN_W-1:0]  s_tdata,
    // [0] mode
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [2:0] status, [54:3] phys_out, [56:55] hit_size_code, [63:57] zero
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int PAD_W  = OUT_W - ST_W - PA_W - SZ_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t             state_reg,    state_next;
    logic [FILL_W-1:0]  fill_reg,     fill_next;
    logic [IDX_W-1:0]   cmp_idx_reg,  cmp_idx_next;
    logic               mode_reg,     mode_next;
    logic [VA_W-1:0]    va_reg,       va_next;
    logic [PA_W-1:0]    pa_reg,       pa_next;
    logic [SZ_W-1:0]    code_reg,     code_next;
    logic [LEN_W-1:0]   len_reg,      len_next;
    logic               hit_reg,      hit_next;
    logic [OFF_W-1:0]   off_reg,      off_next;
    logic [PA_W-1:0]    hit_phys_reg, hit_phys_next;
    logic [SZ_W-1:0]    hit_size_reg, hit_size_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg,  m_tdata_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    entry_t             wr_data;
    entry_t             rd_data;
    cover_t             cov;

    logic               full;
    logic [PAGE_W-1:0]  end_sum;
    logic               crosses;
    logic [PA_W-1:0]    phys_sum;
    status_t            res_status;
    logic [PA_W-1:0]    res_phys;
    logic [SZ_W-1:0]    res_size;

    mpstlb_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // entry read last cycle against the held address
    mpstlb_cover u_cover (
        .va     (va_reg),
        .entry  (rd_data),
        .result (cov)
    );

    assign full = (fill_reg == FILL_W'(ENTRIES));

    // finish-cycle checks on the registered hit
    assign end_sum  = {1'b0, off_reg} + {{(PAGE_W-LEN_W){1'b0}}, len_reg};
    assign crosses  = end_sum > page_bytes(hit_size_reg);
    assign phys_sum = hit_phys_reg + {{(PA_W-OFF_W){1'b0}}, off_reg};

    // new entry; size code three is kept as 1 GiB
    assign wr_data.virt = va_reg;
    assign wr_data.phys = pa_reg;
    assign wr_data.size = (code_reg > SZ_1G) ? SZ_1G : code_reg;

    always_comb
    begin
        res_status = ST_OK;
        res_phys   = '0;
        res_size   = '0;
        if (mode_reg == MODE_INSERT)
        begin
            if (hit_reg)
            begin
                res_status = ST_COVERED;
                res_size   = hit_size_reg;
            end
            else if (full)
            begin
                res_status = ST_FULL;
            end
        end
        else
        begin
            if (!hit_reg)
            begin
                res_status = ST_MISS;
            end
            else if (crosses)
            begin
                res_status = ST_CROSS;
                res_size   = hit_size_reg;
            end
            else
            begin
                res_phys = phys_sum;
                res_size = hit_size_reg;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        cmp_idx_next  = cmp_idx_reg;
        mode_next     = mode_reg;
        va_next       = va_reg;
        pa_next       = pa_reg;
        code_next     = code_reg;
        len_next      = len_reg;
        hit_next      = hit_reg;
        off_next      = off_reg;
        hit_phys_next = hit_phys_reg;
        hit_size_next = hit_size_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next = s_tuser;
                    va_next   = s_tdata[VA_W-1:0];
                    pa_next   = s_tdata[VA_W+PA_W-1:VA_W];
                    code_next = s_tdata[VA_W+PA_W+SZ_W-1:VA_W+PA_W];
                    len_next  = s_tdata[VA_W+PA_W+SZ_W+LEN_W-1:VA_W+PA_W+SZ_W];
                    hit_next  = 1'b0;
                    if (fill_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = IDX_W'(fill_reg - 1'b1);
                        cmp_idx_next = IDX_W'(fill_reg - 1'b1);
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cov.covered)
                begin
                    hit_next      = 1'b1;
                    off_next      = cov.off;
                    hit_phys_next = rd_data.phys;
                    hit_size_next = rd_data.size;
                    state_next    = S_FINISH;
                end
                else if (cmp_idx_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = cmp_idx_reg - 1'b1;
                    cmp_idx_next = cmp_idx_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, res_size, res_phys, res_status};
                    if (mode_reg == MODE_INSERT && !hit_reg && !full)
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
            cmp_idx_reg  <= cmp_idx_next;
            mode_reg     <= mode_next;
            va_reg       <= va_next;
            pa_reg       <= pa_next;
            code_reg     <= code_next;
            len_reg      <= len_next;
            hit_reg      <= hit_next;
            off_reg      <= off_next;
            hit_phys_reg <= hit_phys_next;
            hit_size_reg <= hit_size_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(ENTRIES))
        else $error("fill count above capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full && state_reg == S_FINISH)
        else $error("entry write without room");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count did not follow write");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[ST_W-1:0] == ST_FULL) |-> full)
        else $error("full status with free entries");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> {1'b0, cmp_idx_reg} < fill_reg)
        else $error("scan index beyond stored entries");

endmodule

`default_nettype wire

// ===== rtl/mpstlb_store.sv =====
// ============================================================================
// mpstlb_store
// Entry memory: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module mpstlb_store
    import mpstlb_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  wire entry_t                     wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
    output entry_t                          rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/mpstlb_cover.sv =====
// ============================================================================
// mpstlb_cover
// Range check of one entry against an address, offset into its page.
// ============================================================================
`default_nettype none

module mpstlb_cover
    import mpstlb_pkg::*;
(
    input  wire logic [VA_W-1:0] va,
    input  wire entry_t          entry,
    output cover_t               result
);

    logic [VA_W:0] diff;

    // 65-bit subtract: top bit set means address below base
    assign diff = {1'b0, va} - {1'b0, entry.virt};

    assign result.covered = !diff[VA_W] &&
        (diff[VA_W-1:0] < {{(VA_W-PAGE_W){1'b0}}, page_bytes(entry.size)});
    assign result.off = diff[OFF_W-1:0];

endmodule

`default_nettype wire

// ===== verif/tb_mixed_page_size_tlb.sv =====
// ============================================================================
// tb_mixed_page_size_tlb
// Stream-level test of the mixed page size TLB: a directed set of inserts and
// translates over the page-size corners, then random traffic clustered so
// that mappings overlap and the store fills up. Each accepted word is run
// through an in-bench TLB model and the results are checked in order.
// ============================================================================
`default_nettype none

module tb_mixed_page_size_tlb;
    import mpstlb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TLB_DEPTH    = ENTRIES_DEF;
    localparam int          RANDOM_WORDS = 1280;
    localparam int          TAIL_CYCLES  = 200;      // longer than a full scan of the store
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          MAX_GAP      = 5;
    localparam int          SHOWN_ERRORS = 10;
    localparam logic [63:0] BYTES_4K     = 64'd4096;
    localparam logic [63:0] BYTES_2M     = 64'd2097152;
    localparam logic [63:0] BYTES_1G     = 64'd1073741824;
    localparam logic [12:0] LEN_MAX      = 13'd4096;
    // size code three is stored as 1 GiB
    localparam logic [SZ_W-1:0] SZ_ALIAS_1G = 2'd3;

    typedef struct {
        logic              mode;
        logic [VA_W-1:0]   va;
        logic [PA_W-1:0]   pa;
        logic [SZ_W-1:0]   code;
        logic [LEN_W-1:0]  len;
        int                gap;
        bit                drain;   // hold off until all results are back
    } tlb_word_t;

    typedef struct {
        status_t           status;
        logic [PA_W-1:0]   phys;
        logic [SZ_W-1:0]   size;
    } tlb_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // stimulus and expected results
    tlb_word_t         stim_q[$];
    tlb_reply_t        outcome_q[$];
    logic [VA_W-1:0]   hist_va[$];      // every insert sent, stored or not
    logic [SZ_W-1:0]   hist_code[$];
    bit                send_calm;
    bit                drain_next;
    int                words_total;
    int                words_taken;
    int                mismatches;
    longint            cycles;

    // TLB model state
    logic [VA_W-1:0]   tbl_virt[TLB_DEPTH];
    logic [PA_W-1:0]   tbl_phys[TLB_DEPTH];
    logic [SZ_W-1:0]   tbl_size[TLB_DEPTH];
    int                tbl_fill;

    // driver / monitor state
    tlb_word_t         cur_word;
    bit                have_word;
    int                idle_left;
    int                stall_left;
    bit                ready_calm;
    int                replies_seen;

    mixed_page_size_tlb dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] span_of(input logic [SZ_W-1:0] code);
        logic [63:0] bytes;
        case (code)
            SZ_4K:   bytes = BYTES_4K;
            SZ_2M:   bytes = BYTES_2M;
            default: bytes = BYTES_1G;
        endcase
        return bytes;
    endfunction

    function automatic logic [63:0] rand_u64();
        return {$urandom(), $urandom()};
    endfunction

    // newest covering entry, -1 if none; compares are plain 64-bit
    // unsigned, so no wrap at the top of the address space
    function automatic int newest_cover(input logic [VA_W-1:0] va);
        int idx;
        idx = -1;
        for (int i = 0; i < tbl_fill; i++)
        begin
            if (va >= tbl_virt[i] && (va - tbl_virt[i]) < span_of(tbl_size[i]))
                idx = i;
        end
        return idx;
    endfunction

    // result of one word, updating the model store on a fresh insert
    function automatic tlb_reply_t tlb_outcome(input tlb_word_t w);
        tlb_reply_t  r;
        int          hit;
        logic [63:0] off;
        r.status = ST_OK;
        r.phys   = '0;
        r.size   = SZ_4K;
        hit = newest_cover(w.va);
        if (w.mode == MODE_INSERT)
        begin
            if (hit >= 0)
            begin
                r.status = ST_COVERED;
                r.size   = tbl_size[hit];
            end
            else if (tbl_fill >= TLB_DEPTH)
                r.status = ST_FULL;
            else
            begin
                tbl_virt[tbl_fill] = w.va;
                tbl_phys[tbl_fill] = w.pa;
                tbl_size[tbl_fill] = (w.code == SZ_ALIAS_1G) ? SZ_1G : w.code;
                tbl_fill++;
            end
        end
        else if (hit < 0)
            r.status = ST_MISS;
        else
        begin
            off    = w.va - tbl_virt[hit];
            r.size = tbl_size[hit];
            if (off + 64'(w.len) > span_of(tbl_size[hit]))
                r.status = ST_CROSS;
            else
                r.phys = tbl_phys[hit] + off[PA_W-1:0];   // wraps at 52 bits
        end
        return r;
    endfunction

    task automatic add_word(input logic mode, input logic [VA_W-1:0] va,
                            input logic [PA_W-1:0] pa, input logic [SZ_W-1:0] code,
                            input logic [LEN_W-1:0] len);
        tlb_word_t w;
        w.mode  = mode;
        w.va    = va;
        w.pa    = pa;
        w.code  = code;
        w.len   = len;
        w.gap   = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        w.drain = drain_next;
        drain_next = 1'b0;
        stim_q.push_back(w);
        if (mode == MODE_INSERT)
        begin
            hist_va.push_back(va);
            hist_code.push_back(code);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%0t mismatch %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    endtask

    // driver: one word in flight, idle gap drawn per word
    always @(posedge clk)
    begin
        bit hold;
        bit go;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            have_word = 1'b0;
            idle_left = 0;
        end
        else
        begin
            hold = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
            begin
                outcome_q.push_back(tlb_outcome(cur_word));
                words_taken++;
                have_word = 1'b0;
            end
            if (!hold)
            begin
                if (!have_word && stim_q.size() != 0)
                begin
                    cur_word  = stim_q.pop_front();
                    idle_left = cur_word.gap;
                    have_word = 1'b1;
                end
                go = 1'b0;
                if (have_word && idle_left > 0)
                    idle_left--;
                else if (have_word)
                    go = !(cur_word.drain && outcome_q.size() != 0);
                s_tvalid <= go;
                if (go)
                begin
                    s_tdata <= {5'b0, cur_word.len, cur_word.code, cur_word.pa, cur_word.va};
                    s_tuser <= cur_word.mode;
                end
            end
        end
    end

    // monitor: random ready stalls, in-order compare
    always @(posedge clk)
    begin
        tlb_reply_t got;
        tlb_reply_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
            ready_calm = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[2:0]);
                got.phys   = m_tdata[54:3];
                got.size   = m_tdata[56:55];
                if (outcome_q.size() == 0)
                    flag_mismatch("unexpected word", '0, m_tdata);
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status)
                        flag_mismatch("status", want.status, got.status);
                    if (got.phys != want.phys)
                        flag_mismatch("phys_out", want.phys, got.phys);
                    if (got.size != want.size)
                        flag_mismatch("hit_size_code", want.size, got.size);
                end
                replies_seen++;
                if (replies_seen % 128 == 0)
                    ready_calm = ($urandom_range(0, 2) == 0);
                stall_left = ready_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [63:0]      cluster;
        logic [63:0]      va;
        logic [63:0]      base;
        logic [63:0]      sz;
        logic [SZ_W-1:0]  code;
        logic [LEN_W-1:0] len;
        int               pick;
        int               idx;

        send_calm  = 1'b0;
        drain_next = 1'b0;
        tbl_fill   = 0;
        cluster    = rand_u64() & ~64'h3_FFFF_FFFF;

        // --- directed ---
        // empty store
        add_word(MODE_XLATE, 64'h0, '0, SZ_4K, 13'd0);
        // 4K at zero; last byte, one past the end, zero length, longest fitting
        add_word(MODE_INSERT, 64'h0, '0, SZ_4K, 13'd0);
        add_word(MODE_XLATE, 64'h0, '1, SZ_ALIAS_1G, 13'd0);
        add_word(MODE_XLATE, 64'hFFF, '0, SZ_4K, 13'd1);
        add_word(MODE_XLATE, 64'hFFF, '0, SZ_4K, 13'd2);
        add_word(MODE_XLATE, 64'h0, '0, SZ_4K, 13'd4095);
        add_word(MODE_XLATE, 64'h0, '0, SZ_4K, LEN_MAX);
        // start inside a stored page
        add_word(MODE_INSERT, 64'h800, 52'h1234, SZ_2M, 13'd0);
        // 2M with all-ones physical base: the sum wraps
        add_word(MODE_INSERT, 64'h4000_0000, '1, SZ_2M, 13'h1FFF);
        add_word(MODE_XLATE, 64'h4000_0000 + 64'h1F_FFFF, '0, SZ_4K, 13'd1);
        add_word(MODE_XLATE, 64'h4000_0123, '0, SZ_4K, LEN_MAX);
        // size code three lands as 1 GiB
        add_word(MODE_INSERT, 64'h1_0000_0000, 52'h5_5555_5555_5555, SZ_ALIAS_1G, 13'd0);
        add_word(MODE_XLATE, 64'h1_3FFF_F000, '0, SZ_4K, LEN_MAX);
        add_word(MODE_XLATE, 64'h1_3FFF_F001, '0, SZ_4K, LEN_MAX);
        // unaligned 1G whose end lies past the top of the address space
        add_word(MODE_INSERT, 64'hFFFF_FFFF_C000_0005, 52'hA_AAAA_AAAA_AAAA, SZ_1G, 13'd0);
        add_word(MODE_XLATE, 64'hFFFF_FFFF_FFFF_FFFF, '0, SZ_4K, 13'd0);
        add_word(MODE_XLATE, 64'hFFFF_FFFF_FFFF_FFFF, '0, SZ_4K, LEN_MAX);
        add_word(MODE_XLATE, 64'hFFFF_FFFF_C000_0004, '0, SZ_4K, 13'd0);
        add_word(MODE_INSERT, 64'hFFFF_FFFF_FFFF_F000, '0, SZ_4K, 13'd0);
        // overlap: newer 2M shadows an older unaligned 4K
        add_word(MODE_INSERT, 64'h0000_7FFF_0000_0ABC, 52'h8_0000_0000_0001, SZ_4K, 13'd0);
        add_word(MODE_INSERT, 64'h0000_7FFE_FFF0_0000, 52'h0_0000_0FED_C000, SZ_2M, 13'd0);
        add_word(MODE_XLATE, 64'h0000_7FFF_0000_0ABC, '0, SZ_4K, 13'd16);
        add_word(MODE_XLATE, 64'h5555_5555_5555_5555, '0, SZ_4K, 13'd7);

        // --- random: clustered inserts, translates aimed at known pages ---
        drain_next = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? LEN_MAX : 13'd0)
                                              : 13'($urandom_range(0, 4096));
            if ($urandom_range(0, 9) < 3)
            begin
                code = ($urandom_range(0, 9) == 0) ? SZ_ALIAS_1G
                                                   : SZ_W'($urandom_range(0, 2));
                sz   = span_of(code);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    va = cluster + (rand_u64() & 64'h3_FFFF_FFFF);
                else if (pick < 8)
                begin
                    idx = $urandom_range(0, hist_va.size() - 1);
                    va  = hist_va[idx] + (rand_u64() & ((sz << 1) - 1)) - sz;
                end
                else
                    va = rand_u64();
                if ($urandom_range(0, 1))
                    va = va & ~(sz - 1);
                add_word(MODE_INSERT, va, PA_W'(rand_u64()), code, len);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    idx  = $urandom_range(0, hist_va.size() - 1);
                    base = hist_va[idx];
                    sz   = span_of(hist_code[idx]);
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        va = base + (rand_u64() & (sz - 1));
                    else if (pick < 8)
                        va = base + sz - 64'($urandom_range(0, 4096));
                    else if (pick < 9)
                        va = base - 64'($urandom_range(1, 4096));
                    else
                        va = base + sz + 64'($urandom_range(0, 4096));
                end
                else if (pick < 9)
                    va = cluster + (rand_u64() & 64'h3_FFFF_FFFF);
                else
                    va = rand_u64();
                add_word(MODE_XLATE, va, PA_W'(rand_u64()), SZ_W'($urandom_range(0, 3)), len);
            end
        end
        words_total = stim_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken < words_total || outcome_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/mpstlb_pkg.sv
rtl/mpstlb_store.sv
rtl/mpstlb_cover.sv
rtl/mixed_page_size_tlb.sv
verif/tb_mixed_page_size_tlb.sv
